// ===== rtl/core/ftbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbc_pkg
// shared widths, constants, codes and lane control types for the
// force/torque bias calibration and low-pass block
// ----------------------------------------------------------------------------
package ftbc_pkg;

  localparam int ID_W        = 29;
  localparam int VAL_W       = 32;
  localparam int ALPHA_W     = 16;
  localparam int CNT_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 29;

  localparam int NUM_AXES    = 6;
  localparam int AXES_PER_CH = 3;
  localparam int NUM_CH      = 2;

  // accumulator holds up to 65535 samples of a 32 bit value
  localparam int ACC_W       = 48;
  localparam int DIV_STEPS   = ACC_W;
  localparam int DIV_CNT_W   = 6;

  // filter datapath widths
  localparam int DIFF_W      = VAL_W + 1;
  localparam int PROD_W      = 50;
  localparam int SUM_W       = 51;
  localparam int FRAC_W      = 16;
  localparam int QUOT_W      = SUM_W - FRAC_W;

  localparam logic [CNT_W-1:0]   COUNT_MAX   = 16'hFFFF;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3932;
  localparam logic [CNT_W-1:0]   CALIB_RESET = 16'd100;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam logic signed [SUM_W-1:0] RND_POS = 51'sd32768;
  localparam logic signed [SUM_W-1:0] RND_NEG = 51'sd32767;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_COUNT = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_CALIB   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_VALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic load;
    logic accum;
    logic bias_start;
    logic filt_start;
  } lane_ctrl_t;

  typedef struct packed {
    logic bias_done;
    logic filt_done;
  } lane_stat_t;

endpackage

// ===== rtl/core/ft_bias_calibrate_lowpass.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ft_bias_calibrate_lowpass
// sequence: a word passes update, check and output while calibrating or
//   on an unknown id, and the filter sequence in each lane once calibrated;
//   the word that completes calibration also runs the 48-step bit-serial
//   divider; no new word is taken until the last result is in the output reg
// reset: synchronous active low, clears all sums, counts, biases and filter
//   state, registers return to their defaults, no clearing pass
// ----------------------------------------------------------------------------
module ft_bias_calibrate_lowpass (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic        [ftbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ftbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic        [ftbc_pkg::ID_W-1:0]       in_msg_id,
  input  logic signed [ftbc_pkg::VAL_W-1:0]      in_val_x,
  input  logic signed [ftbc_pkg::VAL_W-1:0]      in_val_y,
  input  logic signed [ftbc_pkg::VAL_W-1:0]      in_val_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [ftbc_pkg::STATUS_W-1:0]   out_status,
  output logic signed [ftbc_pkg::VAL_W-1:0]      out_force_fx,
  output logic signed [ftbc_pkg::VAL_W-1:0]      out_force_fy,
  output logic signed [ftbc_pkg::VAL_W-1:0]      out_force_fz,
  output logic signed [ftbc_pkg::VAL_W-1:0]      out_torque_tx,
  output logic signed [ftbc_pkg::VAL_W-1:0]      out_torque_ty,
  output logic signed [ftbc_pkg::VAL_W-1:0]      out_torque_tz
);
  import ftbc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b00_0001,
    S_UPD  = 6'b00_0010,
    S_CHK  = 6'b00_0100,
    S_BIAS = 6'b00_1000,
    S_FILT = 6'b01_0000,
    S_OUT  = 6'b10_0000
  } state_t;

  state_t                                state_r;
  logic [ID_W-1:0]                       force_id_r;
  logic [ID_W-1:0]                       torque_id_r;
  logic [ALPHA_W-1:0]                    alpha_r;
  logic [CNT_W-1:0]                      calib_count_r;

  logic                                  match_r;
  logic                                  ch_r;
  logic [AXES_PER_CH-1:0][VAL_W-1:0]     val_r;
  logic [NUM_CH-1:0][CNT_W-1:0]          cnt_r;
  logic                                  calibrated_r;

  logic                                  accept;
  logic                                  acc_ok;
  logic                                  need_cal;
  logic                                  run_filt;
  logic                                  bias_done;
  logic                                  filt_done;
  logic                                  out_free;
  logic                                  out_load;
  logic [STATUS_W-1:0]                   status_nxt;

  lane_ctrl_t [NUM_AXES-1:0]             lane_ctrl;
  lane_stat_t [NUM_AXES-1:0]             lane_stat;
  logic [NUM_AXES-1:0][VAL_W-1:0]        lane_filt;
  logic [NUM_AXES-1:0]                   bias_done_vec;
  logic [NUM_AXES-1:0]                   filt_done_vec;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_id_r    <= '0;
      torque_id_r   <= '0;
      alpha_r       <= ALPHA_RESET;
      calib_count_r <= CALIB_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FORCE_ID:    force_id_r    <= cfg_wdata[ID_W-1:0];
        REG_TORQUE_ID:   torque_id_r   <= cfg_wdata[ID_W-1:0];
        REG_ALPHA:       alpha_r       <= cfg_wdata[ALPHA_W-1:0];
        REG_CALIB_COUNT: calib_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input word capture, force id wins on a tie
  always_ff @(posedge clk) begin
    if (accept) begin
      match_r  <= (in_msg_id == force_id_r) || (in_msg_id == torque_id_r);
      ch_r     <= (in_msg_id != force_id_r);
      val_r[0] <= in_val_x;
      val_r[1] <= in_val_y;
      val_r[2] <= in_val_z;
    end
  end

  always_comb begin
    acc_ok   = !calibrated_r && (cnt_r[ch_r] != COUNT_MAX);
    need_cal = match_r && !calibrated_r &&
               (cnt_r[0] >= calib_count_r) && (cnt_r[1] >= calib_count_r);
    run_filt = match_r && calibrated_r;

    bias_done = &bias_done_vec;
    filt_done = &filt_done_vec;
    out_load  = (state_r == S_OUT) && out_free;

    if (!match_r) begin
      status_nxt = STATUS_UNKNOWN;
    end else if (calibrated_r) begin
      status_nxt = STATUS_VALID;
    end else begin
      status_nxt = STATUS_CALIB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      calibrated_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (match_r && acc_ok) begin
            cnt_r[ch_r] <= cnt_r[ch_r] + 1'b1;
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (need_cal) begin
            state_r <= S_BIAS;
          end else if (run_filt) begin
            state_r <= S_FILT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_BIAS: begin
          if (bias_done) begin
            calibrated_r <= 1'b1;
            state_r      <= S_CHK;
          end
        end
        S_FILT: begin
          if (filt_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    localparam int CH  = i / AXES_PER_CH;
    localparam int AX  = i % AXES_PER_CH;

    always_comb begin
      lane_ctrl[i].load       = (state_r == S_UPD) && match_r && (ch_r == 1'(CH));
      lane_ctrl[i].accum      = lane_ctrl[i].load && acc_ok;
      lane_ctrl[i].bias_start = (state_r == S_CHK) && need_cal;
      lane_ctrl[i].filt_start = (state_r == S_CHK) && !need_cal && run_filt;
    end

    assign bias_done_vec[i] = lane_stat[i].bias_done;
    assign filt_done_vec[i] = lane_stat[i].filt_done;

    ftbc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl[i]),
      .raw_in ($signed(val_r[AX])),
      .count  (cnt_r[CH]),
      .alpha  (alpha_r),
      .stat   (lane_stat[i]),
      .filt   (lane_filt[i])
    );
  end

  ftbc_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (out_load),
    .status_in     (status_nxt),
    .filt_in       (lane_filt),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_force_fx  (out_force_fx),
    .out_force_fy  (out_force_fy),
    .out_force_fz  (out_force_fz),
    .out_torque_tx (out_torque_tx),
    .out_torque_ty (out_torque_ty),
    .out_torque_tz (out_torque_tz)
  );

endmodule

// ===== rtl/core/ftbc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbc_lane
// one axis lane: raw value, accumulator, bit-serial bias divider and
// first-order low-pass filter with rounding and saturation
// ----------------------------------------------------------------------------
module ftbc_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ftbc_pkg::lane_ctrl_t                ctrl,
  input  logic signed [ftbc_pkg::VAL_W-1:0]   raw_in,
  input  logic        [ftbc_pkg::CNT_W-1:0]   count,
  input  logic        [ftbc_pkg::ALPHA_W-1:0] alpha,
  output ftbc_pkg::lane_stat_t                stat,
  output logic signed [ftbc_pkg::VAL_W-1:0]   filt
);
  import ftbc_pkg::*;

  typedef enum logic [9:0] {
    L_IDLE = 10'b00_0000_0001,
    L_BABS = 10'b00_0000_0010,
    L_BRND = 10'b00_0000_0100,
    L_BDIV = 10'b00_0000_1000,
    L_BSAT = 10'b00_0001_0000,
    L_FDIF = 10'b00_0010_0000,
    L_FMUL = 10'b00_0100_0000,
    L_FSUM = 10'b00_1000_0000,
    L_FRND = 10'b01_0000_0000,
    L_FSAT = 10'b10_0000_0000
  } lane_state_t;

  lane_state_t                state_r;
  logic signed [VAL_W-1:0]    raw_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [VAL_W-1:0]    bias_r;
  logic signed [VAL_W-1:0]    filt_r;

  logic                       neg_r;
  logic [CNT_W-1:0]           den_r;
  logic [ACC_W-1:0]           numq_r;
  logic [CNT_W-1:0]           rem_r;
  logic [DIV_CNT_W-1:0]       step_r;

  logic signed [DIFF_W-1:0]   d_r;
  logic signed [PROD_W-1:0]   pa_r;
  logic signed [PROD_W-1:0]   pb_r;
  logic signed [SUM_W-1:0]    s_r;
  logic signed [SUM_W-1:0]    t_r;

  logic signed [ACC_W-1:0]    raw_ext;
  logic [ACC_W-1:0]           acc_mag;
  logic [CNT_W:0]             trial;
  logic                       fits;
  logic [CNT_W:0]             diff;
  logic signed [VAL_W-1:0]    bias_nxt;

  logic signed [ALPHA_W:0]    alpha_s;
  logic [ALPHA_W:0]           beta;
  logic signed [ALPHA_W+1:0]  beta_s;
  logic signed [PROD_W-1:0]   pa_nxt;
  logic signed [PROD_W-1:0]   pb_nxt;
  logic signed [QUOT_W-1:0]   q;
  logic signed [VAL_W-1:0]    filt_nxt;

  always_comb begin
    raw_ext = {{(ACC_W-VAL_W){raw_in[VAL_W-1]}}, raw_in};
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

    trial = {rem_r, numq_r[ACC_W-1]};
    fits  = (trial >= {1'b0, den_r});
    diff  = trial - {1'b0, den_r};

    if (den_r == '0) begin
      bias_nxt = '0;
    end else if (!neg_r) begin
      bias_nxt = (|numq_r[ACC_W-1:VAL_W-1]) ? VAL_MAX : $signed(numq_r[VAL_W-1:0]);
    end else if ((|numq_r[ACC_W-1:VAL_W]) ||
                 (numq_r[VAL_W-1] && (|numq_r[VAL_W-2:0]))) begin
      bias_nxt = VAL_MIN;
    end else begin
      bias_nxt = $signed(VAL_W'(-numq_r[VAL_W-1:0]));
    end

    alpha_s = $signed({1'b0, alpha});
    beta    = (ALPHA_W+1)'((ALPHA_W+2)'(1) << ALPHA_W) - (ALPHA_W+1)'(alpha);
    beta_s  = $signed({1'b0, beta});
    pa_nxt  = alpha_s * d_r;
    pb_nxt  = beta_s * filt_r;

    q = t_r[SUM_W-1:FRAC_W];
    if ((&q[QUOT_W-1:VAL_W-1]) || !(|q[QUOT_W-1:VAL_W-1])) begin
      filt_nxt = q[VAL_W-1:0];
    end else begin
      filt_nxt = q[QUOT_W-1] ? VAL_MIN : VAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      raw_r   <= '0;
      acc_r   <= '0;
      bias_r  <= '0;
      filt_r  <= '0;
    end else begin
      if (ctrl.load) begin
        raw_r <= raw_in;
      end
      if (ctrl.accum) begin
        acc_r <= acc_r + raw_ext;
      end
      unique case (state_r)
        L_IDLE: begin
          if (ctrl.bias_start) begin
            state_r <= L_BABS;
          end else if (ctrl.filt_start) begin
            state_r <= L_FDIF;
          end
        end
        L_BABS: begin
          neg_r   <= acc_r[ACC_W-1];
          numq_r  <= acc_mag;
          den_r   <= count;
          state_r <= L_BRND;
        end
        L_BRND: begin
          // round to nearest, ties away from zero
          numq_r  <= numq_r + ACC_W'(den_r >> 1);
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= L_BDIV;
        end
        L_BDIV: begin
          rem_r  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
          numq_r <= {numq_r[ACC_W-2:0], fits};
          step_r <= step_r + 1'b1;
          if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= L_BSAT;
          end
        end
        L_BSAT: begin
          bias_r  <= bias_nxt;
          state_r <= L_IDLE;
        end
        L_FDIF: begin
          d_r     <= DIFF_W'(raw_r) - DIFF_W'(bias_r);
          state_r <= L_FMUL;
        end
        L_FMUL: begin
          pa_r    <= pa_nxt;
          pb_r    <= pb_nxt;
          state_r <= L_FSUM;
        end
        L_FSUM: begin
          s_r     <= {pa_r[PROD_W-1], pa_r} + {pb_r[PROD_W-1], pb_r};
          state_r <= L_FRND;
        end
        L_FRND: begin
          t_r     <= s_r + (s_r[SUM_W-1] ? RND_NEG : RND_POS);
          state_r <= L_FSAT;
        end
        L_FSAT: begin
          filt_r  <= filt_nxt;
          state_r <= L_IDLE;
        end
        default: begin
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  assign stat.bias_done = (state_r == L_BSAT);
  assign stat.filt_done = (state_r == L_FSAT);
  assign filt           = filt_r;

endmodule

// ===== rtl/core/ftbc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbc_merge
// gathers status and the six lane outputs into one result word and holds
// it in the output register until taken
// ----------------------------------------------------------------------------
module ftbc_merge (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  load,
  input  logic [ftbc_pkg::STATUS_W-1:0]                         status_in,
  input  logic [ftbc_pkg::NUM_AXES-1:0][ftbc_pkg::VAL_W-1:0]    filt_in,
  output logic                                                  free,
  output logic                                                  out_valid,
  input  logic                                                  out_stall,
  output logic [ftbc_pkg::STATUS_W-1:0]                         out_status,
  output logic signed [ftbc_pkg::VAL_W-1:0]                     out_force_fx,
  output logic signed [ftbc_pkg::VAL_W-1:0]                     out_force_fy,
  output logic signed [ftbc_pkg::VAL_W-1:0]                     out_force_fz,
  output logic signed [ftbc_pkg::VAL_W-1:0]                     out_torque_tx,
  output logic signed [ftbc_pkg::VAL_W-1:0]                     out_torque_ty,
  output logic signed [ftbc_pkg::VAL_W-1:0]                     out_torque_tz
);
  import ftbc_pkg::*;

  logic                                  valid_r;
  logic [STATUS_W-1:0]                   status_r;
  logic [NUM_AXES-1:0][VAL_W-1:0]        word_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_in;
      word_r   <= filt_in;
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_force_fx  = $signed(word_r[0]);
  assign out_force_fy  = $signed(word_r[1]);
  assign out_force_fz  = $signed(word_r[2]);
  assign out_torque_tx = $signed(word_r[3]);
  assign out_torque_ty = $signed(word_r[4]);
  assign out_torque_tz = $signed(word_r[5]);

endmodule
